@@ rtl/core/psvm_pkg.sv @@
`default_nettype none

package psvm_pkg;

  // Field widths of the input and result words
  localparam int TYPE_W   = 2;
  localparam int SLOT_W   = 3;
  localparam int GAIN_W   = 16;
  localparam int INDEX_W  = 12;
  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 13;
  localparam int COUNT_W  = 5;

  // Mixing arithmetic: Q1.15 sample times Q4.12 gain, scaled down by 12 bits
  localparam int FRAC_SHIFT = 12;
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
  localparam int TERM_W     = PROD_W - FRAC_SHIFT;

  // Width wide enough to compare any field against any parameter value
  localparam int CMP_W = 17;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [TYPE_W-1:0] {
    REQ_TICK    = 2'd0,
    REQ_TRIGGER = 2'd1,
    REQ_WRITE   = 2'd2,
    REQ_LENGTH  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_MIX,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/psvm_if.sv @@
`default_nettype none

// Request channel: one word per tick, trigger, sample write or length update
interface psvm_in_if;
  import psvm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [TYPE_W-1:0]          req_type;
  logic [SLOT_W-1:0]          slot;
  logic [GAIN_W-1:0]          gain;
  logic [INDEX_W-1:0]         word_index;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic [LEN_W-1:0]           slot_length;

  modport source (
    output valid, req_type, slot, gain, word_index, sample_value, slot_length,
    input  ready
  );

  modport sink (
    input  valid, req_type, slot, gain, word_index, sample_value, slot_length,
    output ready
  );
endinterface

// Result channel: one word per request
interface psvm_out_if;
  import psvm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       mix_valid;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic                       clipped;
  logic                       trigger_accepted;
  logic [COUNT_W-1:0]         voices_active;

  modport source (
    output valid, mix_valid, left_sample, right_sample, clipped, trigger_accepted,
           voices_active,
    input  ready
  );

  modport sink (
    input  valid, mix_valid, left_sample, right_sample, clipped, trigger_accepted,
           voices_active,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/polyphonic_sample_voice_mixer_unit.sv @@
// Channel | Dir | Handshake     | Word
// in_ch   | in  | valid / ready | req_type, slot, gain, word_index, sample_value, slot_length
// out_ch  | out | valid / ready | mix_valid, left/right_sample, clipped, trigger_accepted,
//         |     |               | voices_active
//
// A tick runs the voice loop, which feeds one voice per cycle through a single
// sample-memory read port and one shared multiply-accumulate, then drains that pipe
// and presents the result. A trigger runs the one-voice-per-cycle free search.
// Reset (synchronous, rst_n low) frees all voices and empties all slots; sample memory
// is not cleared. A stalled result waits in the output register while the next word is
// accepted and processed; only the final hand-off waits for the output to drain.
`default_nettype none

module polyphonic_sample_voice_mixer_unit #(
  parameter int NUM_SLOTS  = 8,
  parameter int SLOT_DEPTH = 4096,
  parameter int MAX_VOICES = 16
) (
  input  logic clk,
  input  logic rst_n,
  psvm_in_if.sink    in_ch,
  psvm_out_if.source out_ch
);
  import psvm_pkg::*;

  localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int VW    = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CNT_W = $clog2(MAX_VOICES + 1);
  localparam int MEM_D = NUM_SLOTS * SLOT_DEPTH;
  localparam int AW    = $clog2(MEM_D);
  localparam int SUM_W = TERM_W + $clog2(MAX_VOICES + 1);

  // Sequencer and item registers
  state_t              state_r, state_nxt;
  req_t                req_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [VW-1:0]       vidx_r;
  logic                drain_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                acc_r;

  // Slot lengths and voice state
  logic [LEN_W-1:0]    len_tab_r [NUM_SLOTS];
  logic [SW-1:0]       v_slot_r  [MAX_VOICES];
  logic [LEN_W-1:0]    v_pos_r   [MAX_VOICES];
  logic [GAIN_W-1:0]   v_gain_r  [MAX_VOICES];
  logic [MAX_VOICES-1:0] v_busy_r;

  // Sample memory and mixing pipe
  logic signed [SAMPLE_W-1:0] mem [MEM_D];
  logic signed [SAMPLE_W-1:0] rd_r;
  logic                       s1_hit_r;
  logic [GAIN_W-1:0]          s1_gain_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       s2_hit_r;
  logic signed [SUM_W-1:0]    sum_r;

  // Output register
  logic                       out_valid_r;
  logic                       out_mix_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_clip_r;
  logic                       out_trig_r;
  logic [COUNT_W-1:0]         out_voices_r;

  logic                 in_acc;
  logic                 in_slot_ok;
  logic                 slot_ok_r;
  logic [LEN_W-1:0]     in_len_sat;
  logic [AW-1:0]        wr_addr;
  logic                 wr_en;
  logic                 cur_busy;
  logic [LEN_W-1:0]     cur_pos;
  logic [SW-1:0]        cur_slot;
  logic [SW-1:0]        len_addr;
  logic [LEN_W-1:0]     len_rd;
  logic                 mixing;
  logic                 hit;
  logic [LEN_W-1:0]     pos_inc;
  logic                 free_now;
  logic [AW-1:0]        rd_addr;
  logic                 last_v;
  logic                 trig_ok;
  logic                 claim;
  logic signed [GAIN_W:0]     gain_s;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [TERM_W-1:0]   term;
  logic signed [SAMPLE_W-1:0] sat_sample;
  logic                       sat_clip;
  logic                       out_ld;

  // Accept a word only between items
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Decode the incoming word
  assign in_slot_ok = CMP_W'(in_ch.slot) < CMP_W'(NUM_SLOTS);
  assign in_len_sat = (CMP_W'(in_ch.slot_length) > CMP_W'(SLOT_DEPTH)) ?
                      LEN_W'(SLOT_DEPTH) : in_ch.slot_length;
  assign wr_en      = in_acc && (req_t'(in_ch.req_type) == REQ_WRITE) && in_slot_ok &&
                      (CMP_W'(in_ch.word_index) < CMP_W'(SLOT_DEPTH));
  assign wr_addr    = AW'(in_ch.slot) * AW'(SLOT_DEPTH) + AW'(in_ch.word_index);

  // Current voice under the loop counter
  assign cur_busy = v_busy_r[vidx_r];
  assign cur_pos  = v_pos_r[vidx_r];
  assign cur_slot = v_slot_r[vidx_r];
  assign mixing   = (state_r == ST_MIX);
  assign len_addr = mixing ? cur_slot : SW'(slot_r);
  assign len_rd   = len_tab_r[len_addr];
  assign last_v   = (vidx_r == VW'(MAX_VOICES - 1));

  // Per-voice play step: add if within length, advance, free at the end
  assign hit      = mixing && cur_busy && (cur_pos < len_rd);
  assign pos_inc  = cur_pos + LEN_W'(hit);
  assign free_now = mixing && cur_busy && (pos_inc >= len_rd);
  assign rd_addr  = AW'(cur_slot) * AW'(SLOT_DEPTH) + AW'(cur_pos);

  // Trigger: claim the lowest free voice of a loaded slot
  assign slot_ok_r = CMP_W'(slot_r) < CMP_W'(NUM_SLOTS);
  assign trig_ok   = slot_ok_r && (len_rd != '0);
  assign claim     = (state_r == ST_TRIG) && trig_ok && !cur_busy;

  // Shared multiply and scale
  assign gain_s   = $signed({1'b0, s1_gain_r});
  assign prod_nxt = PROD_W'(rd_r) * PROD_W'(gain_s);
  assign term     = TERM_W'(prod_r >>> FRAC_SHIFT);

  // Saturate the frame sum
  always_comb begin
    sat_sample = SAMPLE_W'(sum_r);
    sat_clip   = 1'b0;
    if (sum_r > SUM_W'(SAMPLE_MAX)) begin
      sat_sample = SAMPLE_MAX;
      sat_clip   = 1'b1;
    end else if (sum_r < SUM_W'(SAMPLE_MIN)) begin
      sat_sample = SAMPLE_MIN;
      sat_clip   = 1'b1;
    end
  end

  assign out_ld = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (req_t'(in_ch.req_type))
            REQ_TICK:    state_nxt = ST_MIX;
            REQ_TRIGGER: state_nxt = ST_TRIG;
            default:     state_nxt = ST_DONE;
          endcase
        end
      end
      ST_TRIG: begin
        if (claim || !trig_ok || last_v) state_nxt = ST_DONE;
      end
      ST_MIX: begin
        if (last_v) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_r) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_ld) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control: loop counter, drain timer, voice flags and count, slot lengths, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vidx_r      <= '0;
      drain_r     <= 1'b0;
      cnt_r       <= '0;
      acc_r       <= 1'b0;
      v_busy_r    <= '0;
      s1_hit_r    <= 1'b0;
      s2_hit_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        len_tab_r[i] <= '0;
      end
    end else begin
      s1_hit_r <= hit;
      s2_hit_r <= s1_hit_r;
      drain_r  <= (state_r == ST_DRAIN) ? !drain_r : 1'b0;

      if (in_acc) begin
        vidx_r <= '0;
        acc_r  <= 1'b0;
      end else if ((state_r == ST_TRIG) || mixing) begin
        vidx_r <= vidx_r + VW'(1);
      end

      if (in_acc && (req_t'(in_ch.req_type) == REQ_LENGTH) && in_slot_ok) begin
        len_tab_r[SW'(in_ch.slot)] <= in_len_sat;
      end

      if (claim) begin
        v_busy_r[vidx_r] <= 1'b1;
        cnt_r            <= cnt_r + CNT_W'(1);
        acc_r            <= 1'b1;
      end else if (free_now) begin
        v_busy_r[vidx_r] <= 1'b0;
        cnt_r            <= cnt_r - CNT_W'(1);
      end

      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item, voice and pipe payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= req_t'(in_ch.req_type);
      slot_r <= in_ch.slot;
      gain_r <= in_ch.gain;
    end

    if (claim) begin
      v_slot_r[vidx_r] <= SW'(slot_r);
      v_pos_r[vidx_r]  <= '0;
      v_gain_r[vidx_r] <= gain_r;
    end else if (hit) begin
      v_pos_r[vidx_r]  <= pos_inc;
    end

    s1_gain_r <= v_gain_r[vidx_r];
    prod_r    <= prod_nxt;

    if (in_acc) begin
      sum_r <= '0;
    end else if (s2_hit_r) begin
      sum_r <= sum_r + SUM_W'(term);
    end
  end

  // Sample memory write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_ch.sample_value;
    end
  end

  // Sample memory read port
  always_ff @(posedge clk) begin
    rd_r <= mem[rd_addr];
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_mix_r    <= (req_r == REQ_TICK);
      out_sample_r <= (req_r == REQ_TICK) ? sat_sample : '0;
      out_clip_r   <= (req_r == REQ_TICK) && sat_clip;
      out_trig_r   <= acc_r;
      out_voices_r <= COUNT_W'(cnt_r);
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.mix_valid        = out_mix_r;
  assign out_ch.left_sample      = out_sample_r;
  assign out_ch.right_sample     = out_sample_r;
  assign out_ch.clipped          = out_clip_r;
  assign out_ch.trigger_accepted = out_trig_r;
  assign out_ch.voices_active    = out_voices_r;

endmodule

`default_nettype wire

@@ rtl/core/psvm_checker.sv @@
`default_nettype none

module psvm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_mix_valid,
  input logic signed [psvm_pkg::SAMPLE_W-1:0] out_left,
  input logic signed [psvm_pkg::SAMPLE_W-1:0] out_right,
  input logic                             out_clipped,
  input logic                             out_trig
);
  import psvm_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_clipped) &&
    $stable(out_mix_valid) && $stable(out_trig))
    else $error("result word changed while stalled");

  // One item at a time: the block drops ready after taking a word
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after accepting a word");

  // Non-tick results carry silence and no clip
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_mix_valid |-> out_left == '0 && out_right == '0 && !out_clipped)
    else $error("non-tick result carries audio");

  // Clip only at a rail, and both channels agree
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> out_left == out_right &&
    (out_left == SAMPLE_MAX || out_left == SAMPLE_MIN))
    else $error("clip flag without a saturated sample");

  // A tick never reports a started voice
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mix_valid |-> !out_trig)
    else $error("tick result flags a trigger");

endmodule

bind polyphonic_sample_voice_mixer_unit psvm_checker u_psvm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_mix_valid (out_ch.mix_valid),
  .out_left      (out_ch.left_sample),
  .out_right     (out_ch.right_sample),
  .out_clipped   (out_ch.clipped),
  .out_trig      (out_ch.trigger_accepted)
);

`default_nettype wire

@@ verif/tb_top.sv @@
`default_nettype none

module tb_top;
  import psvm_pkg::*;

  localparam int NSLOT         = 8;
  localparam int DEPTH         = 4096;
  localparam int NVOICE        = 16;
  localparam int RANDOM_ITEMS  = 1550;
  localparam int TAIL_CYCLES   = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam longint TIMEOUT_UNITS = 64'd10_000_000;

  typedef struct {
    req_t                       kind;
    logic [SLOT_W-1:0]          slot;
    logic [GAIN_W-1:0]          gain;
    logic [INDEX_W-1:0]         index;
    logic signed [SAMPLE_W-1:0] sample;
    logic [LEN_W-1:0]           length;
  } mix_request_t;

  typedef struct {
    logic                       mix_valid;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       clipped;
    logic                       trig_ok;
    logic [COUNT_W-1:0]         voices;
  } mix_frame_t;

  // Shadow copy of the voice engine plus the queue of frames it still owes
  class mixer_shadow;
    logic signed [SAMPLE_W-1:0] store [NSLOT*DEPTH];
    logic [LEN_W-1:0]           slot_len [NSLOT];
    logic [SLOT_W-1:0]          v_slot [NVOICE];
    logic [LEN_W-1:0]           v_pos [NVOICE];
    logic [GAIN_W-1:0]          v_gain [NVOICE];
    bit                         v_busy [NVOICE];
    mix_frame_t                 pending_frames [$];
    int errors, frames, clip_frames, starts, refusals, peak_voices;

    function new();
      foreach (store[i]) store[i] = '0;
      foreach (slot_len[i]) slot_len[i] = '0;
      foreach (v_busy[i]) begin
        v_busy[i] = 1'b0;
        v_slot[i] = '0;
        v_pos[i]  = '0;
        v_gain[i] = '0;
      end
      errors = 0;
      frames = 0;
      clip_frames = 0;
      starts = 0;
      refusals = 0;
      peak_voices = 0;
    endfunction

    function bit slot_playing(int s);
      foreach (v_busy[v])
        if (v_busy[v] && v_slot[v] == s) return 1'b1;
      return 1'b0;
    endfunction

    // Apply one accepted request word and queue the frame it must produce
    function void note_request(mix_request_t r);
      mix_frame_t f;
      longint     sum;
      int         n;
      bit         placed;
      f.mix_valid = 1'b0;
      f.left      = '0;
      f.right     = '0;
      f.clipped   = 1'b0;
      f.trig_ok   = 1'b0;
      case (r.kind)
        REQ_TICK: begin
          sum = 0;
          for (int v = 0; v < NVOICE; v++) begin
            if (v_busy[v]) begin
              // each term is floored, so shift the full product arithmetically
              if (v_pos[v] < slot_len[v_slot[v]]) begin
                sum += (longint'(store[int'(v_slot[v]) * DEPTH + int'(v_pos[v])])
                        * longint'(v_gain[v])) >>> FRAC_SHIFT;
                v_pos[v]++;
              end
              if (v_pos[v] >= slot_len[v_slot[v]]) v_busy[v] = 1'b0;
            end
          end
          if (sum > longint'(SAMPLE_MAX)) begin
            sum = longint'(SAMPLE_MAX);
            f.clipped = 1'b1;
          end else if (sum < longint'(SAMPLE_MIN)) begin
            sum = longint'(SAMPLE_MIN);
            f.clipped = 1'b1;
          end
          f.mix_valid = 1'b1;
          f.left      = sum[SAMPLE_W-1:0];
          f.right     = sum[SAMPLE_W-1:0];
          frames++;
          if (f.clipped) clip_frames++;
        end
        REQ_TRIGGER: begin
          placed = 1'b0;
          // take the lowest free voice, only for a slot that holds data
          if (slot_len[r.slot] != 0) begin
            for (int v = 0; v < NVOICE; v++) begin
              if (!placed && !v_busy[v]) begin
                v_busy[v] = 1'b1;
                v_slot[v] = r.slot;
                v_pos[v]  = '0;
                v_gain[v] = r.gain;
                placed    = 1'b1;
              end
            end
          end
          f.trig_ok = placed;
          if (placed) starts++;
          else refusals++;
        end
        REQ_WRITE: store[int'(r.slot) * DEPTH + int'(r.index)] = r.sample;
        REQ_LENGTH: slot_len[r.slot] = (r.length > DEPTH) ? LEN_W'(DEPTH) : r.length;
      endcase
      n = 0;
      foreach (v_busy[v])
        if (v_busy[v]) n++;
      f.voices = n[COUNT_W-1:0];
      if (n > peak_voices) peak_voices = n;
      pending_frames.insert(pending_frames.size(), f);
    endfunction

    function string frame_text(mix_frame_t f);
      return $sformatf("mix=%0b left=%0d right=%0d clip=%0b trig=%0b voices=%0d",
                       f.mix_valid, f.left, f.right, f.clipped, f.trig_ok, f.voices);
    endfunction

    // Compare one accepted result word against the oldest owed frame
    function void check_frame(mix_frame_t got);
      mix_frame_t want;
      if (pending_frames.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result word: %s", frame_text(got));
        return;
      end
      want = pending_frames.pop_front();
      if (got.mix_valid !== want.mix_valid || got.left !== want.left ||
          got.right !== want.right || got.clipped !== want.clipped ||
          got.trig_ok !== want.trig_ok || got.voices !== want.voices) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result word mismatch\n  expected %s\n  actual   %s",
                   frame_text(want), frame_text(got));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  psvm_in_if  in_ch ();
  psvm_out_if out_ch ();

  polyphonic_sample_voice_mixer_unit #(
    .NUM_SLOTS  (NSLOT),
    .SLOT_DEPTH (DEPTH),
    .MAX_VOICES (NVOICE)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mixer_shadow shadow;
  int tx_idle_pct;
  int rx_stall_pct;
  int rx_hold_left;
  int sent;
  // words written so far per slot, and the length of the written run from word 0
  bit wr_map [NSLOT][DEPTH];
  int wr_prefix [NSLOT];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fill every field with noise, then fix the request type and slot
  function automatic mix_request_t base_req(req_t k, int s);
    mix_request_t r;
    r.kind   = k;
    r.slot   = s[SLOT_W-1:0];
    r.gain   = GAIN_W'($urandom);
    r.index  = INDEX_W'($urandom);
    r.sample = SAMPLE_W'($urandom);
    r.length = LEN_W'($urandom);
    return r;
  endfunction

  // Offer one request word, hold it until accepted, then update the shadow
  task automatic send_req(mix_request_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= r.kind;
    in_ch.slot         <= r.slot;
    in_ch.gain         <= r.gain;
    in_ch.word_index   <= r.index;
    in_ch.sample_value <= r.sample;
    in_ch.slot_length  <= r.length;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    shadow.note_request(r);
    if (r.kind == REQ_WRITE) begin
      wr_map[r.slot][r.index] = 1'b1;
      while (wr_prefix[r.slot] < DEPTH && wr_map[r.slot][wr_prefix[r.slot]])
        wr_prefix[r.slot]++;
    end
    sent++;
  endtask

  task automatic write_word(int s, int idx, int value);
    mix_request_t r;
    r = base_req(REQ_WRITE, s);
    r.index  = idx[INDEX_W-1:0];
    r.sample = value[SAMPLE_W-1:0];
    send_req(r);
  endtask

  task automatic set_len(int s, int len);
    mix_request_t r;
    r = base_req(REQ_LENGTH, s);
    r.length = len[LEN_W-1:0];
    send_req(r);
  endtask

  task automatic trigger(int s, int g);
    mix_request_t r;
    r = base_req(REQ_TRIGGER, s);
    r.gain = g[GAIN_W-1:0];
    send_req(r);
  endtask

  task automatic ticks(int n);
    repeat (n) send_req(base_req(REQ_TICK, $urandom_range(NSLOT-1)));
  endtask

  // Mostly modest gains so that clipping stays one outcome among several
  function automatic int pick_gain();
    case ($urandom_range(3))
      0: return $urandom_range(65535);
      1: return $urandom_range(1) ? 65535 : 0;
      default: return $urandom_range(6000);
    endcase
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 32767 : -32768;
      1: return $urandom_range(1024) - 512;
      default: return $urandom_range(65535);
    endcase
  endfunction

  function automatic int playable_slot();
    int s;
    s = $urandom_range(NSLOT-1);
    for (int i = 0; i < NSLOT; i++)
      if (shadow.slot_len[(s + i) % NSLOT] != 0) return (s + i) % NSLOT;
    return s;
  endfunction

  // Keep lengths inside the written run; an oversized length is set only on an
  // idle slot and replaced by the very next word
  task automatic random_length(int s);
    if (wr_prefix[s] < DEPTH && !shadow.slot_playing(s) && $urandom_range(15) == 0) begin
      set_len(s, $urandom_range(8191, wr_prefix[s] + 1));
      set_len(s, wr_prefix[s]);
    end else if ($urandom_range(1)) begin
      set_len(s, wr_prefix[s]);
    end else begin
      set_len(s, $urandom_range(wr_prefix[s], 0));
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (shadow.pending_frames.size() != 0) @(posedge clk);
  endtask

  // Result side: check accepted words, then pick next ready
  initial begin
    mix_frame_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.mix_valid = out_ch.mix_valid;
        got.left      = out_ch.left_sample;
        got.right     = out_ch.right_sample;
        got.clipped   = out_ch.clipped;
        got.trig_ok   = out_ch.trigger_accepted;
        got.voices    = out_ch.voices_active;
        shadow.check_frame(got);
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("ERROR: timeout with %0d result words outstanding",
             shadow.pending_frames.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus
  initial begin
    int phase;
    int next_phase;
    int start;
    int goal;
    int pick;
    int s;
    bit held;
    shadow = new();
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.req_type     <= REQ_TICK;
    in_ch.slot         <= '0;
    in_ch.gain         <= '0;
    in_ch.word_index   <= '0;
    in_ch.sample_value <= '0;
    in_ch.slot_length  <= '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_left = 0;
    sent         = 0;
    held         = 1'b0;
    phase        = 0;
    foreach (wr_prefix[i]) wr_prefix[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: silent frame and trigger on an empty slot
    ticks(1);
    trigger(0, 4096);
    // full-scale words, voices at maximum and zero gain, clip both ways
    write_word(0, 0, 32767);
    write_word(0, 1, -32768);
    write_word(0, 2, -1);
    write_word(0, 3, 1);
    set_len(0, 4);
    trigger(0, 65535);
    trigger(0, 0);
    ticks(2);
    // shorten under playing voices: they add nothing and free on the next frame
    set_len(0, 1);
    ticks(1);
    // oversized length saturates; a tiny negative term floors to -1
    write_word(1, 0, -1);
    set_len(1, 8191);
    set_len(1, 1);
    trigger(1, 1);
    ticks(1);
    write_word(7, 4095, -32768);
    // emptied slot refuses a trigger
    set_len(0, 0);
    trigger(0, 65535);
    set_len(0, 4);
    drain_results();

    start = sent;
    goal  = sent + RANDOM_ITEMS;
    while (sent < goal) begin
      // advance pacing phase once the previous one has fully drained
      next_phase = ((sent - start) * 4) / RANDOM_ITEMS;
      if (next_phase > 3) next_phase = 3;
      if (next_phase != phase) begin
        drain_results();
        phase = next_phase;
        case (phase)
          1: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
          2: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
          default: begin tx_idle_pct = 29; rx_stall_pct = 29; end
        endcase
      end
      // one long output hold-off while requests keep coming
      if (!held && sent - start > 150) begin
        rx_hold_left = HOLD_CYCLES;
        held = 1'b1;
      end

      pick = $urandom_range(99);
      if (pick < 34) begin
        ticks($urandom_range(6, 1));
      end else if (pick < 56) begin
        repeat ($urandom_range(3, 1)) trigger(playable_slot(), pick_gain());
      end else if (pick < 77) begin
        s = $urandom_range(NSLOT-1);
        repeat ($urandom_range(8, 1))
          if (wr_prefix[s] < DEPTH) write_word(s, wr_prefix[s], pick_sample());
      end else if (pick < 87) begin
        random_length($urandom_range(NSLOT-1));
      end else if (pick < 90) begin
        // flood triggers to run out of voices
        s = playable_slot();
        repeat ($urandom_range(20, 17)) trigger(s, pick_gain());
      end else begin
        case ($urandom_range(2))
          0: write_word($urandom_range(NSLOT-1), $urandom_range(4095), pick_sample());
          1: trigger($urandom_range(NSLOT-1), $urandom_range(65535));
          default: ticks(1);
        endcase
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run: %0d request words, %0d mixed frames (%0d clipped), %0d voice starts,",
             sent, shadow.frames, shadow.clip_frames, shadow.starts);
    $display("     %0d refused starts, peak %0d busy voices, %0d mismatching words.",
             shadow.refusals, shadow.peak_voices, shadow.errors);
    if (shadow.errors == 0 && shadow.pending_frames.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
